### sv/linear_fit_residual_outliers_defines.svh
// Assertion macros shared by the checker of the linear fit block.
`ifndef LINEAR_FIT_RESIDUAL_OUTLIERS_DEFINES_SVH
`define LINEAR_FIT_RESIDUAL_OUTLIERS_DEFINES_SVH

// same-cycle implication, reset masks the check
`define LFRO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("linear fit check failed");

// next-cycle implication, reset masks the check
`define LFRO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linear fit check failed");

`endif

### sv/lfro_pkg.sv
// Package: constants, state encoding and control structs of the linear fit block.
`timescale 1ns / 1ps
`default_nettype none
package lfro_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int DVD_W = 60;
  localparam int DSR_W = 44;
  localparam int OUT_W = 280;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FEW  = 2'd1;
  localparam logic [1:0] STATUS_FLAT = 2'd2;

  typedef enum logic [1:0] {
    DIV_SLOPE,
    DIV_ICPT,
    DIV_SST
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_FIT1,
    ST_FIT2,
    ST_CHECK,
    ST_ERR,
    ST_DIVB,
    ST_DIVB_W,
    ST_AMUL,
    ST_DIVA,
    ST_DIVA_W,
    ST_P2_RD,
    ST_P2_S1,
    ST_P2_S2,
    ST_P2_S3,
    ST_P2_ACC,
    ST_SST,
    ST_SST_W,
    ST_P3_RD,
    ST_P3_S1,
    ST_P3_S2,
    ST_P3_S3,
    ST_P3_S4,
    ST_P3_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     fit1;
    logic     fit2;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_b;
    logic     amul;
    logic     take_a;
    logic     take_sst;
    logic     acc_clr;
    logic     acc;
    logic     idx_clr;
    logic     idx_inc;
    logic     emit_pt;
    logic     emit_err;
    logic     clear_set;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic den_pos;
    logic idx_last;
    logic out_free;
    logic div_done;
  } sts_t;

  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    logic signed [23:0] r;
    if (v > 34'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -34'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32q(input logic [DVD_W-1:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > DVD_W'(32'h7fffffff)) ? 32'h7fffffff : q[31:0];
    end else begin
      r = (q > DVD_W'(33'h080000000)) ? 32'h80000000 : (32'd0 - q[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/linear_fit_residual_outliers.sv
// Top level: least-squares line fit with residuals and outlier flags.
// Input channel s_*: one beat per (x, y) point in signed Q8.8; s_tlast ends the
//   data set and starts the fit. Points beyond 64 are dropped, their mark kept.
// Output channel m_*: one beat per stored point in index order, m_tlast on the
//   final one; fewer than three points or all x equal give a single beat with
//   a nonzero status and every other field zero.
// Loading takes one cycle per point. After the marked point the block forms the
//   products, runs the check, then the slope divide, the intercept product, the
//   intercept divide, the residual pass, the SST divide and the result pass; the
//   three divides share one divider that yields one quotient bit per cycle.
// s_tready is high only while loading; a pending output beat does not block
//   the next data set once the last result is in the output register.
// A stalled receiver holds the output register and pauses the result pass.
// Reset (rst, synchronous) empties the data set and the output register; the
//   point stores keep no reset value.
`timescale 1ns / 1ps
`default_nettype none
module linear_fit_residual_outliers (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // x_value[15:0], y_value[31:16]
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [279:0]      m_tdata,   // point_index, fitted_value, residual,
                                       // residual_squared, is_outlier, slope,
                                       // intercept, sum_sq_residual, sum_sq_total,
                                       // status, zero pad
  output logic              m_tlast
);

  lfro_pkg::cmd_t cmd;
  lfro_pkg::sts_t sts;

  lfro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfro_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

### sv/lfro_div.sv
// Restoring divider: one quotient bit per cycle over unsigned magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module lfro_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lfro_pkg::DVD_W-1:0]    dividend,
  input  wire logic [lfro_pkg::DSR_W-1:0]    divisor,
  output logic      [lfro_pkg::DVD_W-1:0]    quotient,
  output logic                               done
);

  localparam int CNT_W = $clog2(lfro_pkg::DVD_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [lfro_pkg::DSR_W:0]      rem;
  logic [lfro_pkg::DSR_W-1:0]    dsr;
  logic [lfro_pkg::DSR_W:0]      shifted;
  logic                          qbit;

  assign shifted = {rem[lfro_pkg::DSR_W-1:0], quotient[lfro_pkg::DVD_W-1]};
  assign qbit    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(lfro_pkg::DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= qbit ? (shifted - {1'b0, dsr}) : shifted;
      quotient <= {quotient[lfro_pkg::DVD_W-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

### sv/lfro_datapath.sv
// Datapath: point stores, sums, fit arithmetic, residual pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none
module lfro_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lfro_pkg::cmd_t               cmd,
  output lfro_pkg::sts_t                    sts,
  input  wire logic [31:0]                  in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lfro_pkg::OUT_W-1:0]        out_data,
  output logic                              out_last
);

  localparam int AW = lfro_pkg::AW;
  localparam int CW = lfro_pkg::CW;

  logic signed [15:0] xmem [lfro_pkg::MAX_POINTS];
  logic signed [15:0] ymem [lfro_pkg::MAX_POINTS];

  logic [CW-1:0]       count;
  logic signed [21:0]  sx, sy;
  logic signed [37:0]  sxy, sxx;
  logic signed [15:0]  in_x, in_y;
  logic signed [7:0]   n_s;

  logic signed [45:0]  p_nsxx, p_nsxy;
  logic signed [43:0]  p_sxsx, p_sxsy;
  logic signed [46:0]  den, num;

  logic [lfro_pkg::DVD_W-1:0] dvd;
  logic [lfro_pkg::DSR_W-1:0] dsr;
  logic [lfro_pkg::DVD_W-1:0] quo;
  logic                       div_done;
  logic                       neg, neg_next;
  logic [46:0]                num_mag;
  logic signed [55:0]         anum;
  logic [55:0]                anum_mag;

  logic signed [31:0]  b, a;
  logic signed [53:0]  bsx;

  logic [AW-1:0]       idx;
  logic signed [15:0]  xr, yr, yr1, yr2;
  logic signed [47:0]  bx;
  logic signed [23:0]  ny;
  logic signed [48:0]  fsum;
  logic signed [32:0]  fdiv;
  logic signed [32:0]  full;
  logic signed [24:0]  d;
  logic signed [23:0]  yh_c, e_c, yh3, e3, yh4, e4;
  logic signed [47:0]  esq_full;
  logic signed [49:0]  dsq_full;
  logic [46:0]         esq, esq4;
  logic [49:0]         dsq;
  logic [52:0]         oprod;
  logic [52:0]         ssr, sst_sum, sst;

  assign in_x = in_data[15:0];
  assign in_y = in_data[31:16];
  assign n_s  = signed'({1'b0, count});

  lfro_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .quotient (quo),
    .done     (div_done)
  );

  // store and accumulate
  always_ff @(posedge clk) begin
    if (cmd.load && count != CW'(lfro_pkg::MAX_POINTS)) begin
      xmem[count[AW-1:0]] <= in_x;
      ymem[count[AW-1:0]] <= in_y;
    end
    xr <= xmem[idx];
    yr <= ymem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sx    <= '0;
      sy    <= '0;
      sxy   <= '0;
      sxx   <= '0;
    end else if (cmd.clear_set) begin
      count <= '0;
      sx    <= '0;
      sy    <= '0;
      sxy   <= '0;
      sxx   <= '0;
    end else if (cmd.load && count != CW'(lfro_pkg::MAX_POINTS)) begin
      count <= count + 1'b1;
      sx    <= sx + 22'(in_x);
      sy    <= sy + 22'(in_y);
      sxy   <= sxy + 38'(in_x * in_y);
      sxx   <= sxx + 38'(in_x * in_x);
    end
  end

  // fit products and differences
  always_ff @(posedge clk) begin
    if (cmd.fit1) begin
      p_nsxx <= n_s * sxx;
      p_nsxy <= n_s * sxy;
      p_sxsx <= sx * sx;
      p_sxsy <= sx * sy;
    end
    if (cmd.fit2) begin
      den <= 47'(p_nsxx) - 47'(p_sxsx);
      num <= 47'(p_nsxy) - 47'(p_sxsy);
    end
    if (cmd.amul) begin
      bsx <= b * sx;
    end
  end

  assign num_mag  = num[46] ? 47'(-num) : 47'(num);
  assign anum     = (56'(sy) <<< 16) - 56'(bsx);
  assign anum_mag = anum[55] ? 56'(-anum) : 56'(anum);

  always_comb begin
    dvd      = '0;
    dsr      = '0;
    neg_next = 1'b0;
    case (cmd.div_sel)
      lfro_pkg::DIV_SLOPE: begin
        dvd      = {num_mag[43:0], 16'd0};
        dsr      = den[43:0];
        neg_next = num[46];
      end
      lfro_pkg::DIV_ICPT: begin
        dvd      = lfro_pkg::DVD_W'(anum_mag);
        dsr      = lfro_pkg::DSR_W'({count, 8'd0});
        neg_next = anum[55];
      end
      lfro_pkg::DIV_SST: begin
        dvd      = lfro_pkg::DVD_W'(sst_sum);
        dsr      = lfro_pkg::DSR_W'(count * count);
        neg_next = 1'b0;
      end
      default: begin
        dvd      = '0;
        dsr      = '0;
        neg_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= neg_next;
    end
    if (cmd.take_b) begin
      b <= signed'(lfro_pkg::sat32q(quo, neg));
    end
    if (cmd.take_a) begin
      a <= signed'(lfro_pkg::sat32q(quo, neg));
    end
    if (cmd.take_sst) begin
      sst <= quo[52:0];
    end
  end

  // per-point pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  assign fsum     = (49'(a) <<< 8) + 49'(bx);
  assign fdiv     = 33'(fsum >>> 16);
  assign yh_c     = lfro_pkg::sat24(34'(full));
  assign e_c      = lfro_pkg::sat24(34'(yr2) - 34'(full));
  assign esq_full = e_c * e_c;
  assign dsq_full = d * d;

  always_ff @(posedge clk) begin
    bx   <= b * xr;
    ny   <= 24'(n_s * yr);
    yr1  <= yr;
    full <= (fsum[48] && fsum[15:0] != 16'd0) ? fdiv + 33'sd1 : fdiv;
    d    <= 25'(ny) - 25'(sy);
    yr2  <= yr1;
    yh3  <= yh_c;
    e3   <= e_c;
    esq  <= esq_full[46:0];
    dsq  <= dsq_full[49:0];
    yh4  <= yh3;
    e4   <= e3;
    esq4 <= esq;
    oprod <= 53'(esq * (count - CW'(2)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ssr     <= '0;
      sst_sum <= '0;
    end else if (cmd.acc_clr) begin
      ssr     <= '0;
      sst_sum <= '0;
    end else if (cmd.acc) begin
      ssr     <= ssr + 53'(esq);
      sst_sum <= sst_sum + 53'(dsq);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_pt || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_data <= {6'd0, (count < CW'(3)) ? lfro_pkg::STATUS_FEW : lfro_pkg::STATUS_FLAT,
                   272'd0};
      out_last <= 1'b1;
    end else if (cmd.emit_pt) begin
      out_data <= {6'd0, lfro_pkg::STATUS_OK, sst, ssr, a, b,
                   (55'(oprod) > {ssr, 2'b00}), esq4, e4, yh4, 6'(idx)};
      out_last <= sts.idx_last;
    end
  end

  assign sts.few      = (count < CW'(3));
  assign sts.den_pos  = !den[46] && (den != '0);
  assign sts.idx_last = (CW'(idx) == count - 1'b1);
  assign sts.out_free = !out_valid || out_ready;
  assign sts.div_done = div_done;

endmodule
`default_nettype wire

### sv/lfro_ctrl.sv
// Controller: sequences load, fit, residual pass, divisions and result pass.
`timescale 1ns / 1ps
`default_nettype none
module lfro_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  output logic                  in_ready,
  input  wire lfro_pkg::sts_t   sts,
  output lfro_pkg::cmd_t        cmd
);

  lfro_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfro_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = lfro_pkg::DIV_SLOPE;
    in_ready    = 1'b0;
    case (state)
      lfro_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = lfro_pkg::ST_FIT1;
        end
      end
      lfro_pkg::ST_FIT1: begin
        cmd.fit1   = 1'b1;
        state_next = lfro_pkg::ST_FIT2;
      end
      lfro_pkg::ST_FIT2: begin
        cmd.fit2   = 1'b1;
        state_next = lfro_pkg::ST_CHECK;
      end
      lfro_pkg::ST_CHECK: begin
        state_next = (sts.few || !sts.den_pos) ? lfro_pkg::ST_ERR : lfro_pkg::ST_DIVB;
      end
      lfro_pkg::ST_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err  = 1'b1;
          cmd.clear_set = 1'b1;
          state_next    = lfro_pkg::ST_LOAD;
        end
      end
      lfro_pkg::ST_DIVB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = lfro_pkg::DIV_SLOPE;
        state_next    = lfro_pkg::ST_DIVB_W;
      end
      lfro_pkg::ST_DIVB_W: begin
        if (sts.div_done) begin
          cmd.take_b = 1'b1;
          state_next = lfro_pkg::ST_AMUL;
        end
      end
      lfro_pkg::ST_AMUL: begin
        cmd.amul   = 1'b1;
        state_next = lfro_pkg::ST_DIVA;
      end
      lfro_pkg::ST_DIVA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = lfro_pkg::DIV_ICPT;
        state_next    = lfro_pkg::ST_DIVA_W;
      end
      lfro_pkg::ST_DIVA_W: begin
        if (sts.div_done) begin
          cmd.take_a  = 1'b1;
          cmd.acc_clr = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = lfro_pkg::ST_P2_RD;
        end
      end
      lfro_pkg::ST_P2_RD: state_next = lfro_pkg::ST_P2_S1;
      lfro_pkg::ST_P2_S1: state_next = lfro_pkg::ST_P2_S2;
      lfro_pkg::ST_P2_S2: state_next = lfro_pkg::ST_P2_S3;
      lfro_pkg::ST_P2_S3: state_next = lfro_pkg::ST_P2_ACC;
      lfro_pkg::ST_P2_ACC: begin
        cmd.acc     = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = sts.idx_last ? lfro_pkg::ST_SST : lfro_pkg::ST_P2_RD;
      end
      lfro_pkg::ST_SST: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = lfro_pkg::DIV_SST;
        state_next    = lfro_pkg::ST_SST_W;
      end
      lfro_pkg::ST_SST_W: begin
        if (sts.div_done) begin
          cmd.take_sst = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = lfro_pkg::ST_P3_RD;
        end
      end
      lfro_pkg::ST_P3_RD: state_next = lfro_pkg::ST_P3_S1;
      lfro_pkg::ST_P3_S1: state_next = lfro_pkg::ST_P3_S2;
      lfro_pkg::ST_P3_S2: state_next = lfro_pkg::ST_P3_S3;
      lfro_pkg::ST_P3_S3: state_next = lfro_pkg::ST_P3_S4;
      lfro_pkg::ST_P3_S4: state_next = lfro_pkg::ST_P3_OUT;
      lfro_pkg::ST_P3_OUT: begin
        if (sts.out_free) begin
          cmd.emit_pt = 1'b1;
          cmd.idx_inc = 1'b1;
          if (sts.idx_last) begin
            cmd.clear_set = 1'b1;
            state_next    = lfro_pkg::ST_LOAD;
          end else begin
            state_next = lfro_pkg::ST_P3_RD;
          end
        end
      end
      default: state_next = lfro_pkg::ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

### sv/lfro_checker.sv
// Port checker for the linear fit block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_fit_residual_outliers_defines.svh"
module lfro_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [279:0] m_tdata,
  input wire logic         m_tlast
);

  `LFRO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LFRO_ASSERT_NOW(a_err_last, m_tvalid && m_tdata[273:272] != lfro_pkg::STATUS_OK, m_tlast)
  `LFRO_ASSERT_NOW(a_err_zero, m_tvalid && m_tdata[273:272] != lfro_pkg::STATUS_OK, m_tdata[271:0] == '0)
  `LFRO_ASSERT_NOW(a_flag_ok, m_tvalid && m_tdata[101], m_tdata[273:272] == lfro_pkg::STATUS_OK)

endmodule

bind linear_fit_residual_outliers lfro_checker u_lfro_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
